### rtl/keyed_cache_fifo_lru_top_assert.svh
// ----------------------------------------------------------------------------
// Keyed cache assertion macros
// Assertion wrappers for the keyed cache; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef KEYED_CACHE_FIFO_LRU_TOP_ASSERT_SVH
`define KEYED_CACHE_FIFO_LRU_TOP_ASSERT_SVH

`ifndef SYNTH
`define KCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define KCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KCF_ASSERT(lbl, prop, msg)
`define KCF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/kcf_pkg.sv
// ----------------------------------------------------------------------------
// Keyed cache package
// Sizes, operation and register codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package kcf_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned REG_IDX_W = 1;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned KEY_W     = 31;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned IN_BITS   = OP_W + KEY_W + VAL_W;
  localparam int unsigned OUT_BITS  = 1 + VAL_W + 1 + KEY_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [OP_W-1:0]      op_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam op_t OP_GET    = 2'd0;
  localparam op_t OP_PUT    = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;
  localparam op_t OP_UNUSED = 2'd3;

  localparam reg_idx_t REG_CAPACITY = 1'b0;
  localparam reg_idx_t REG_MODE     = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
  localparam logic             MODE_RESET = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RDVAL,
    ST_SWEEP,
    ST_INSERT,
    ST_OUT
  } state_e;

  function automatic logic [CMP_W-1:0] eff_cap(logic [CAP_W-1:0] c);
    logic [CMP_W-1:0] w;
    w = CMP_W'(c);
    if (w == '0) w = CMP_W'(1);
    if (w > CMP_W'(ENTRIES)) w = CMP_W'(ENTRIES);
    return w;
  endfunction

endpackage

### rtl/keyed_cache_fifo_lru_top.sv
// ----------------------------------------------------------------------------
// Keyed cache with FIFO or LRU replacement
// Fully associative key to value cache with get, put and remove requests.
// ----------------------------------------------------------------------------
// One request is taken at a time and one result beat leaves for it. Entry keys,
// values and age ranks sit in small memories that a sequencer walks one entry
// per cycle through a single key comparator and a single rank decrementer: a
// lookup pass over all entries, and for an LRU refresh, an eviction or a remove
// that hits a second rank-update pass. Get miss, FIFO put hit, absent remove and
// unused code go from the decision step straight to the result step; a FIFO get
// hit first reads the value, a put without eviction first inserts, an LRU put
// hit or a remove hit first sweeps, an LRU get hit reads then sweeps and an
// evicting put sweeps then inserts. Ready returns in the cycle after the result
// is loaded; a new request is taken while the previous result still waits on
// the output, and the sequencer holds on its result step only while an earlier
// beat has not been taken.
// ----------------------------------------------------------------------------
`include "keyed_cache_fifo_lru_top_assert.svh"

module keyed_cache_fifo_lru_top
  import kcf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [REG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // operation, key, put_value
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // hit, read_value, evicted, evicted_key
);

  state_e state_q, state_d;

  logic [CAP_W-1:0] cap_q;
  logic             mode_q;

  op_t              op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] pval_q;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pvld_q;
  logic [IDX_W-1:0] pidx_q;

  logic [ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]   occ_q;

  logic             hit_q;
  logic [IDX_W-1:0] sidx_q;
  logic [IDX_W-1:0] srank_q;
  logic             free_found_q;
  logic [IDX_W-1:0] free_idx_q;
  logic             old_found_q;
  logic [IDX_W-1:0] old_idx_q;
  logic [KEY_W-1:0] old_key_q;
  logic [IDX_W-1:0] sweep_rank_q;
  logic             refresh_q;
  logic             ins_pend_q;
  logic             ins_ok_q;
  logic [IDX_W-1:0] ins_idx_q;

  logic [VAL_W-1:0] wk_rd_q;
  logic             wk_ev_q;
  logic [KEY_W-1:0] wk_evk_q;

  logic             out_valid_q;
  logic             out_hit_q;
  logic [VAL_W-1:0] out_rd_q;
  logic             out_ev_q;
  logic [KEY_W-1:0] out_evk_q;

  logic [KEY_W-1:0] key_mem  [ENTRIES];
  logic [VAL_W-1:0] val_mem  [ENTRIES];
  logic [IDX_W-1:0] rank_mem [ENTRIES];
  logic [KEY_W-1:0] key_rd_q;
  logic [VAL_W-1:0] val_rd_q;
  logic [IDX_W-1:0] rank_rd_q;

  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic             key_we;
  logic             val_we;
  logic             rank_we;
  logic [IDX_W-1:0] rank_wdata;

  logic             accept;
  logic             out_load;
  logic             evict_c;
  logic             cnt_end;
  logic [CNT_W-1:0] occ_dec;
  logic             sweep_self;
  logic             sweep_dec;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
  assign cnt_end       = (cnt_q == CNT_W'(ENTRIES));
  assign evict_c       = (CMP_W'(occ_q) >= eff_cap(cap_q)) && old_found_q;
  assign occ_dec       = occ_q - CNT_W'(1);
  assign sweep_self    = refresh_q && (pidx_q == sidx_q);
  assign sweep_dec     = valid_q[pidx_q] && (rank_rd_q > sweep_rank_q);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_evk_q, out_ev_q, out_rd_q, out_hit_q});

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_axis_tvalid) state_d = ST_SCAN;
      ST_SCAN:   if (cnt_end) state_d = ST_DECIDE;
      ST_DECIDE: begin
        case (op_q)
          OP_GET:    state_d = hit_q ? ST_RDVAL : ST_OUT;
          OP_PUT: begin
            if (hit_q) state_d = mode_q ? ST_SWEEP : ST_OUT;
            else       state_d = evict_c ? ST_SWEEP : ST_INSERT;
          end
          OP_REMOVE: state_d = hit_q ? ST_SWEEP : ST_OUT;
          default:   state_d = ST_OUT;
        endcase
      end
      ST_RDVAL:  state_d = mode_q ? ST_SWEEP : ST_OUT;
      ST_SWEEP:  if (cnt_end) state_d = ins_pend_q ? ST_INSERT : ST_OUT;
      ST_INSERT: state_d = ST_OUT;
      ST_OUT:    if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: counter and memory port controls
  always_comb begin
    cnt_d      = '0;
    raddr      = cnt_q[IDX_W-1:0];
    waddr      = pidx_q;
    key_we     = 1'b0;
    val_we     = 1'b0;
    rank_we    = 1'b0;
    rank_wdata = rank_rd_q - IDX_W'(1);
    unique case (state_q)
      ST_SCAN: begin
        cnt_d = cnt_end ? '0 : cnt_q + CNT_W'(1);
      end
      ST_DECIDE: begin
        raddr = sidx_q;
        waddr = sidx_q;
        val_we = (op_q == OP_PUT) && hit_q;
      end
      ST_SWEEP: begin
        cnt_d = cnt_end ? '0 : cnt_q + CNT_W'(1);
        if (pvld_q && sweep_self) begin
          rank_we    = 1'b1;
          rank_wdata = occ_dec[IDX_W-1:0];
        end else if (pvld_q && sweep_dec) begin
          rank_we = 1'b1;
        end
      end
      ST_INSERT: begin
        waddr      = ins_idx_q;
        key_we     = ins_ok_q;
        val_we     = ins_ok_q;
        rank_we    = ins_ok_q;
        rank_wdata = occ_q[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[waddr] <= key_q;
    key_rd_q <= key_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[waddr] <= pval_q;
    val_rd_q <= val_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) rank_mem[waddr] <= rank_wdata;
    rank_rd_q <= rank_mem[raddr];
  end

  // Request payload and per-entry captures
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tdata[OP_W-1:0];
      key_q  <= s_axis_tdata[OP_W +: KEY_W];
      pval_q <= s_axis_tdata[OP_W + KEY_W +: VAL_W];
    end
    pidx_q <= cnt_q[IDX_W-1:0];
    if (state_q == ST_SCAN && pvld_q) begin
      if (valid_q[pidx_q] && key_rd_q == key_q && !hit_q) begin
        sidx_q  <= pidx_q;
        srank_q <= rank_rd_q;
      end
      if (!valid_q[pidx_q] && !free_found_q) free_idx_q <= pidx_q;
      if (valid_q[pidx_q] && rank_rd_q == '0 && !old_found_q) begin
        old_idx_q <= pidx_q;
        old_key_q <= key_rd_q;
      end
    end
    if (state_q == ST_DECIDE) begin
      if (op_q == OP_PUT && !hit_q && evict_c) begin
        sweep_rank_q <= '0;
        ins_idx_q    <= (!free_found_q || old_idx_q < free_idx_q) ? old_idx_q : free_idx_q;
      end else begin
        sweep_rank_q <= srank_q;
        ins_idx_q    <= free_idx_q;
      end
    end
    if (out_load) begin
      out_hit_q <= hit_q;
      out_rd_q  <= wk_rd_q;
      out_ev_q  <= wk_ev_q;
      out_evk_q <= wk_evk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      pvld_q       <= 1'b0;
      cap_q        <= CAP_RESET;
      mode_q       <= MODE_RESET;
      valid_q      <= '0;
      occ_q        <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      old_found_q  <= 1'b0;
      refresh_q    <= 1'b0;
      ins_pend_q   <= 1'b0;
      ins_ok_q     <= 1'b0;
      wk_rd_q      <= '0;
      wk_ev_q      <= 1'b0;
      wk_evk_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pvld_q  <= (state_q == ST_SCAN || state_q == ST_SWEEP) && !cnt_end;

      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_CAPACITY: cap_q  <= cfg_wdata_i[CAP_W-1:0];
          REG_MODE:     mode_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (accept) begin
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
        old_found_q  <= 1'b0;
        refresh_q    <= 1'b0;
        ins_pend_q   <= 1'b0;
        ins_ok_q     <= 1'b0;
        wk_rd_q      <= '0;
        wk_ev_q      <= 1'b0;
        wk_evk_q     <= '0;
      end

      if (state_q == ST_SCAN && pvld_q) begin
        if (valid_q[pidx_q] && key_rd_q == key_q && op_q != OP_UNUSED) hit_q <= 1'b1;
        if (!valid_q[pidx_q]) free_found_q <= 1'b1;
        if (valid_q[pidx_q] && rank_rd_q == '0) old_found_q <= 1'b1;
      end

      if (state_q == ST_DECIDE) begin
        case (op_q)
          OP_GET, OP_PUT: begin
            if (hit_q) begin
              refresh_q <= mode_q;
            end else if (op_q == OP_PUT) begin
              ins_pend_q <= 1'b1;
              if (evict_c) begin
                ins_ok_q           <= 1'b1;
                wk_ev_q            <= 1'b1;
                wk_evk_q           <= old_key_q;
                valid_q[old_idx_q] <= 1'b0;
                occ_q              <= occ_dec;
              end else begin
                ins_ok_q <= free_found_q;
              end
            end
          end
          OP_REMOVE: begin
            if (hit_q) begin
              valid_q[sidx_q] <= 1'b0;
              occ_q           <= occ_dec;
            end
          end
          default: ;
        endcase
      end

      if (state_q == ST_RDVAL) wk_rd_q <= val_rd_q;

      if (state_q == ST_INSERT && ins_ok_q) begin
        valid_q[ins_idx_q] <= 1'b1;
        occ_q              <= occ_q + CNT_W'(1);
      end

      if (out_load)           out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  `KCF_ASSERT(a_occ_bound, (occ_q <= CNT_W'(ENTRIES)), "occupancy above entry count")
  `KCF_ASSERT_ALWAYS(a_reset_quiet, (!rst_ni) |=> !m_axis_tvalid, "result beat during reset")
  `KCF_ASSERT(a_occ_matches, ($countones(valid_q) == int'(occ_q)), "occupancy and valid bits differ")
  `KCF_ASSERT(a_hit_valid, (state_q == ST_DECIDE && hit_q) |-> valid_q[sidx_q], "hit on invalid entry")
  `KCF_ASSERT(a_insert_put, (state_q == ST_INSERT) |-> (op_q == OP_PUT && !hit_q), "insert outside put miss")
  `KCF_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q == ST_OUT), "result beat outside output step")

endmodule

### test/tb_keyed_cache_fifo_lru_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyed cache testbench
// Streams get, put, remove and unused requests into the cache under several
// capacity and replacement settings. A scoreboard cache in the bench tracks
// keys, values and age ranks. It predicts hit, read value and eviction for
// every accepted beat and checks each result beat in order. Both stream
// sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb_keyed_cache_fifo_lru_top;
  import kcf_pkg::*;

  localparam int          PHASES      = 10;
  localparam int          PHASE_ITEMS = 163;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
    op_t              op;
  } request_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } response_t;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  reg_idx_t               cfg_addr_i    = REG_CAPACITY;
  logic [CFG_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // operation, key, put_value
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // hit, read_value, evicted, evicted_key

  keyed_cache_fifo_lru_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Scoreboard copy of the cache
  logic             line_valid [ENTRIES];
  logic [KEY_W-1:0] line_key   [ENTRIES];
  logic [VAL_W-1:0] line_value [ENTRIES];
  logic [4:0]       line_rank  [ENTRIES];
  logic [4:0]       occupancy;
  logic [CAP_W-1:0] cfg_capacity;
  logic             cfg_lru;

  request_t    request_q[$];
  response_t   due_responses[$];
  request_t    held_req;
  logic        idle_en      = 1'b1;
  int          mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned gap_left;
  int unsigned stall_left;

  // Close the gap left by entry s in the age order.
  function automatic void close_rank_gap(int s);
    for (int i = 0; i < ENTRIES; i++)
      if (line_valid[i] && i != s && line_rank[i] > line_rank[s])
        line_rank[i] = line_rank[i] - 5'd1;
  endfunction

  function automatic void make_newest(int s);
    close_rank_gap(s);
    line_rank[s] = occupancy - 5'd1;
  endfunction

  function automatic void drop_line(int s);
    close_rank_gap(s);
    line_valid[s] = 1'b0;
    if (occupancy != 0) occupancy = occupancy - 5'd1;
  endfunction

  function automatic response_t cache_access(request_t r);
    response_t res;
    int        slot;
    int        cap;
    logic      placed;
    res    = '0;
    slot   = -1;
    placed = 1'b0;
    cap    = int'(cfg_capacity);
    if (cap == 0) cap = 1;
    if (cap > ENTRIES) cap = int'(ENTRIES);
    if (r.op != OP_UNUSED)
      for (int i = 0; i < ENTRIES; i++)
        if (slot < 0 && line_valid[i] && line_key[i] == r.key) slot = i;
    case (r.op)
      OP_GET: begin
        if (slot >= 0) begin
          res.hit        = 1'b1;
          res.read_value = line_value[slot];
          if (cfg_lru) make_newest(slot);
        end
      end
      OP_PUT: begin
        if (slot >= 0) begin
          res.hit          = 1'b1;
          line_value[slot] = r.value;
          if (cfg_lru) make_newest(slot);
        end else begin
          if (occupancy >= cap)
            for (int i = 0; i < ENTRIES; i++)
              if (!res.evicted && line_valid[i] && line_rank[i] == 0) begin
                res.evicted     = 1'b1;
                res.evicted_key = line_key[i];
                drop_line(i);
              end
          for (int i = 0; i < ENTRIES; i++)
            if (!placed && !line_valid[i]) begin
              placed        = 1'b1;
              line_valid[i] = 1'b1;
              line_key[i]   = r.key;
              line_value[i] = r.value;
              line_rank[i]  = occupancy;
              occupancy     = occupancy + 5'd1;
            end
        end
      end
      OP_REMOVE: begin
        if (slot >= 0) begin
          res.hit = 1'b1;
          drop_line(slot);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    request_t next_req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        due_responses.push_back(cache_access(held_req));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left      <= gap_left - 1;
        end else if (request_q.size() != 0 && idle_en && $urandom_range(0, 9) == 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left      <= $urandom_range(0, 7);
        end else if (request_q.size() != 0) begin
          next_req = request_q.pop_front();
          held_req      <= next_req;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_TDATA_W'({next_req.value, next_req.key, next_req.op});
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    response_t got;
    response_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit         = m_axis_tdata[0];
        got.read_value  = m_axis_tdata[1 +: VAL_W];
        got.evicted     = m_axis_tdata[VAL_W + 1];
        got.evicted_key = m_axis_tdata[VAL_W + 2 +: KEY_W];
        if (due_responses.size() == 0) begin
          $error("result beat with nothing outstanding: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = due_responses.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
            mismatches++;
          end
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, got.read_value);
            mismatches++;
          end
          if (got.evicted !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
            mismatches++;
          end
          if (got.evicted_key !== want.evicted_key) begin
            $error("evicted_key: expected %h, got %h", want.evicted_key, got.evicted_key);
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= $urandom_range(0, 7);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("keyed_cache_fifo_lru_top regression: fail");
      $finish;
    end
  end

  task automatic queue_request(op_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    request_t r;
    r.op    = op;
    r.key   = key;
    r.value = value;
    request_q.push_back(r);
  endtask

  task automatic drain();
    while (request_q.size() != 0 || s_axis_tvalid || due_responses.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_config(logic [CAP_W-1:0] cap, logic lru);
    logic [CFG_W-1:0] mode_word;
    mode_word    = CFG_W'($urandom);
    mode_word[0] = lru;
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_CAPACITY;
    cfg_wdata_i <= CFG_W'(cap);
    @(posedge clk_i);
    cfg_addr_i  <= REG_MODE;
    cfg_wdata_i <= mode_word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_capacity = cap;
    cfg_lru      = lru;
    @(negedge clk_i);
  endtask

  // Random requests over a small pool of keys so that hits and evictions are common.
  task automatic queue_random_phase(int pool_n);
    logic [KEY_W-1:0] pool[$];
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
    int               pick;
    op_t              op;
    for (int i = 0; i < pool_n; i++)
      pool.push_back((i < pool_n / 2) ? KEY_W'(i) : KEY_W'($urandom));
    repeat (PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      op   = (pick < 35) ? OP_GET : (pick < 75) ? OP_PUT : (pick < 95) ? OP_REMOVE : OP_UNUSED;
      key  = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) : pool[$urandom_range(0, pool_n - 1)];
      case ($urandom_range(0, 19))
        0:       value = '0;
        1:       value = '1;
        default: value = $urandom;
      endcase
      queue_request(op, key, value);
    end
  endtask

  int unsigned phase_cap  [PHASES] = '{16, 4, 0, 31, 1, 8, 16, 3, 0, 16};
  logic        phase_mode [PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0, 0, 0};

  initial begin
    int eff;
    for (int i = 0; i < ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_key[i]   = '0;
      line_value[i] = '0;
      line_rank[i]  = '0;
    end
    occupancy    = '0;
    cfg_capacity = CAP_RESET;
    cfg_lru      = MODE_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty lookups, extreme keys and values, update, unused code,
    // absent remove, then fill to capacity so the all-ones key is evicted.
    queue_request(OP_GET, KEY_W'(5), '0);
    queue_request(OP_PUT, '0, '0);
    queue_request(OP_PUT, '1, '1);
    queue_request(OP_GET, '1, '0);
    queue_request(OP_PUT, '0, 32'ha5a5_a5a5);
    queue_request(OP_UNUSED, '1, '1);
    queue_request(OP_REMOVE, '0, '1);
    queue_request(OP_REMOVE, '0, '0);
    for (int k = 1; k <= 16; k++)
      queue_request(OP_PUT, KEY_W'(k), $urandom);
    drain();

    phase_cap[8]  = $urandom_range(0, 31);
    phase_mode[8] = $urandom_range(0, 1);
    for (int p = 0; p < PHASES; p++) begin
      write_config(CAP_W'(phase_cap[p]), phase_mode[p]);
      eff = (phase_cap[p] == 0) ? 1 : (phase_cap[p] > ENTRIES) ? ENTRIES : phase_cap[p];
      idle_en = (p != PHASES - 1);
      queue_random_phase(eff + 4);
      drain();
    end

    repeat (80) @(posedge clk_i);
    if (mismatches == 0)
      $display("keyed_cache_fifo_lru_top regression: pass");
    else
      $display("keyed_cache_fifo_lru_top regression: fail");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/kcf_pkg.sv
rtl/keyed_cache_fifo_lru_top.sv
test/tb_keyed_cache_fifo_lru_top.sv
